[rtl/ticket_weighted_ready_queue_scheduler_unit_defines.svh]
// Assertion macros used by the scheduler checker.
`ifndef TICKET_WEIGHTED_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define TICKET_WEIGHTED_READY_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TWRQS_CHECK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TWRQS_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/twrqs_pkg.sv]
// Shared constants, codes and control structs of the ready queue scheduler.
package twrqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int MAX_PASSES_DEF  = 256;

	localparam int TAG_W  = 32;
	localparam int TIX_W  = 15;
	localparam int SUM_W  = 24;
	localparam int CNT_W  = 7;
	localparam int LIM_W  = 9;
	localparam int PRIO_W = 8;
	localparam int TIME_W = 32;
	localparam int STAT_W = 3;
	localparam int FUNC_W = 2;

	localparam logic [TIX_W-1:0] TICKETS_PER_PRIO = 15'd100;
	localparam logic [TIX_W-1:0] BOOT_TICKETS     = 15'd500;
	localparam logic [SUM_W-1:0] BOOT_SUM         = 24'd500;
	localparam logic [LIM_W-1:0] LIMIT_RESET      = 9'd32;

	// Item function codes.
	localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SCHED  = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_PRIO     = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOPICK   = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              ld_item;
		logic              add_push;
		logic              idx_clr;
		logic              rm_rd;
		logic              rm_next;
		logic              rm_hit;
		logic              sh_rd;
		logic              sh_wr;
		logic              rm_apply;
		logic              div_mod_go;
		logic              div_win_go;
		logic              walk_init;
		logic              walk_rd;
		logic              walk_pop;
		logic              set_status;
		logic [STAT_W-1:0] status;
		logic              res_load;
	} cmd_t;

	// Conditions reported by the datapath.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              prio_bad;
		logic              full;
		logic              empty;
		logic              count_zero;
		logic              tag_hit;
		logic              rm_last;
		logic              sh_more;
		logic              div_done;
		logic              win;
		logic              pass_end;
		logic              no_gain;
		logic              last_pass;
	} stat_t;

endpackage

[rtl/twrqs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module twrqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/twrqs_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module twrqs_div #(
	parameter int W  = 33,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [W-1:0]  quo,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   trial;
	logic          fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shifting remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/twrqs_dp.sv]
// Datapath: ready queue memory, ring pointers, ticket totals and the draw divider.
module twrqs_dp #(
	parameter int QUEUE_DEPTH = twrqs_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_PASSES  = twrqs_pkg::MAX_PASSES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [twrqs_pkg::FUNC_W-1:0]  func,
	input  logic [twrqs_pkg::TAG_W-1:0]   task_tag,
	input  logic [twrqs_pkg::PRIO_W-1:0]  priority_req,
	input  logic [twrqs_pkg::TIME_W-1:0]  time_count,
	input  logic                          running_ends,
	input  logic                          cfg_we,
	input  logic [twrqs_pkg::LIM_W-1:0]   cfg_wdata,
	input  twrqs_pkg::cmd_t               cmd,
	output twrqs_pkg::stat_t              st,
	output logic [twrqs_pkg::STAT_W-1:0]  status,
	output logic [twrqs_pkg::TAG_W-1:0]   picked_tag,
	output logic [twrqs_pkg::SUM_W-1:0]   ticket_total
);

	localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW      = $clog2(QUEUE_DEPTH + 1);
	localparam int PW      = $clog2(MAX_PASSES + 1);
	localparam int TAG_W   = twrqs_pkg::TAG_W;
	localparam int TIX_W   = twrqs_pkg::TIX_W;
	localparam int SUM_W   = twrqs_pkg::SUM_W;
	localparam int CNT_W   = twrqs_pkg::CNT_W;
	localparam int ENTRY_W = TAG_W + TIX_W;
	localparam int DIV_W   = twrqs_pkg::TIME_W + 1;
	localparam int DIVR_W  = CNT_W + 1;
	localparam int ACC_W   = SUM_W + 1;

	// Item registers.
	logic [twrqs_pkg::FUNC_W-1:0] func_q;
	logic [TAG_W-1:0]             tag_q;
	logic [twrqs_pkg::PRIO_W-1:0] prio_q;
	logic [twrqs_pkg::TIME_W-1:0] time_q;
	logic                         ends_q;

	// Scheduler state.
	logic [twrqs_pkg::LIM_W-1:0]  limit_q;
	logic [AW-1:0]                head_q;
	logic [FW-1:0]                fill_q;
	logic [TAG_W-1:0]             run_tag_q;
	logic [TIX_W-1:0]             run_tix_q;
	logic [SUM_W-1:0]             sum_q;
	logic [CNT_W-1:0]             count_q;

	// Working registers of one item.
	logic [FW-1:0]                idx_q;
	logic [PW-1:0]                pass_q;
	logic [ACC_W-1:0]             acc_q;
	logic                         gain_q;
	logic [SUM_W-1:0]             winner_q;
	logic [TIX_W-1:0]             rm_tix_q;
	logic [twrqs_pkg::STAT_W-1:0] status_q;
	logic [TAG_W-1:0]             picked_q;

	// Result registers.
	logic [twrqs_pkg::STAT_W-1:0] out_status_q;
	logic [TAG_W-1:0]             out_picked_q;
	logic [SUM_W-1:0]             out_total_q;

	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               we;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic [TAG_W-1:0]   rd_tag;
	logic [TIX_W-1:0]   rd_tix;
	logic [TIX_W-1:0]   new_tix;
	logic [AW-1:0]      head_inc;
	logic [FW-1:0]      idx_inc;
	logic [ACC_W-1:0]   acc_next;
	logic               win;
	logic               pass_end;

	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIVR_W-1:0]  div_divisor;
	logic               div_busy;
	logic [DIV_W-1:0]   div_quo;
	logic [DIVR_W-1:0]  div_rem;

	// Ring slot at an offset from the head; the sum stays below twice the depth.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [FW-1:0] off);
		logic [FW:0] s;
		s = (FW+1)'(base) + (FW+1)'(off);
		if (s >= (FW+1)'(QUEUE_DEPTH)) begin
			s = s - (FW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign rd_tag   = rdata[ENTRY_W-1:TIX_W];
	assign rd_tix   = rdata[TIX_W-1:0];
	assign new_tix  = TIX_W'({7'd0, prio_q} * twrqs_pkg::TICKETS_PER_PRIO);
	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign idx_inc  = idx_q + FW'(1);
	assign acc_next = acc_q + ACC_W'(rd_tix);
	assign win      = acc_next >= {1'b0, winner_q};
	assign pass_end = idx_inc == fill_q;

	// Status toward the controller.
	always_comb begin
		st.func       = func_q;
		st.prio_bad   = {1'b0, prio_q} >= limit_q;
		st.full       = fill_q >= FW'(QUEUE_DEPTH);
		st.empty      = fill_q == '0;
		st.count_zero = count_q == '0;
		st.tag_hit    = rd_tag == tag_q;
		st.rm_last    = idx_inc == fill_q;
		st.sh_more    = idx_inc < fill_q;
		st.div_done   = !div_busy;
		st.win        = win;
		st.pass_end   = pass_end;
		st.no_gain    = !gain_q && (rd_tix == '0);
		st.last_pass  = pass_q == PW'(MAX_PASSES - 1);
	end

	// Queue memory addressing; the walk always reads the head.
	always_comb begin
		raddr = head_q;
		if (cmd.rm_rd) begin
			raddr = slot(head_q, idx_q);
		end else if (cmd.sh_rd) begin
			raddr = slot(head_q, idx_inc);
		end else if (cmd.walk_rd) begin
			raddr = head_q;
		end
		we    = 1'b0;
		waddr = slot(head_q, fill_q);
		wdata = {tag_q, new_tix};
		if (cmd.add_push) begin
			we = 1'b1;
		end else if (cmd.sh_wr) begin
			we    = 1'b1;
			waddr = slot(head_q, idx_q);
			wdata = rdata;
		end else if (cmd.walk_pop) begin
			if (win) begin
				we    = !ends_q;
				wdata = {run_tag_q, run_tix_q};
			end else begin
				we    = 1'b1;
				wdata = rdata;
			end
		end
	end

	twrqs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Divider operands: first the tick modulo, then the winning ticket.
	assign div_start    = cmd.div_mod_go || cmd.div_win_go;
	assign div_dividend = cmd.div_mod_go ? DIV_W'(time_q) + DIV_W'(1) : DIV_W'(sum_q);
	assign div_divisor  = cmd.div_mod_go ? {1'b0, count_q} : div_rem + DIVR_W'(1);

	twrqs_div #(
		.W (DIV_W),
		.DW(DIVR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (div_busy),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// Scheduler state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= twrqs_pkg::LIMIT_RESET;
			head_q    <= '0;
			fill_q    <= '0;
			run_tag_q <= '0;
			run_tix_q <= twrqs_pkg::BOOT_TICKETS;
			sum_q     <= twrqs_pkg::BOOT_SUM;
			count_q   <= CNT_W'(1);
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.add_push) begin
				fill_q  <= fill_q + FW'(1);
				sum_q   <= sum_q + SUM_W'(new_tix);
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.rm_apply) begin
				fill_q  <= fill_q - FW'(1);
				sum_q   <= sum_q - SUM_W'(rm_tix_q);
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.walk_pop) begin
				head_q <= head_inc;
				if (win) begin
					run_tag_q <= rd_tag;
					run_tix_q <= rd_tix;
					if (ends_q) begin
						fill_q  <= fill_q - FW'(1);
						sum_q   <= sum_q - SUM_W'(rd_tix);
						count_q <= count_q - CNT_W'(1);
					end else begin
						sum_q <= sum_q - SUM_W'(rd_tix) + SUM_W'(run_tix_q);
					end
				end
			end
		end
	end

	// Item, working and result registers.
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			func_q   <= func;
			tag_q    <= task_tag;
			prio_q   <= priority_req;
			time_q   <= time_count;
			ends_q   <= running_ends;
			picked_q <= '0;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end
		if (cmd.rm_next || cmd.sh_wr) begin
			idx_q <= idx_inc;
		end
		if (cmd.rm_hit) begin
			rm_tix_q <= rd_tix;
		end
		if (cmd.walk_init) begin
			acc_q    <= '0;
			pass_q   <= '0;
			idx_q    <= '0;
			gain_q   <= 1'b0;
			winner_q <= div_quo[SUM_W-1:0];
		end
		if (cmd.walk_pop) begin
			if (win) begin
				picked_q <= rd_tag;
			end else begin
				acc_q <= acc_next;
				if (pass_end) begin
					idx_q  <= '0;
					pass_q <= pass_q + PW'(1);
					gain_q <= 1'b0;
				end else begin
					idx_q  <= idx_inc;
					gain_q <= gain_q || (rd_tix != '0);
				end
			end
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.res_load) begin
			out_status_q <= status_q;
			out_picked_q <= picked_q;
			out_total_q  <= sum_q;
		end
	end

	assign status       = out_status_q;
	assign picked_tag   = out_picked_q;
	assign ticket_total = out_total_q;

endmodule

[rtl/twrqs_ctrl.sv]
// Controller state machine that sequences add, remove and schedule items.
module twrqs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  twrqs_pkg::stat_t st,
	output twrqs_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_RM_RD  = 4'd2;
	localparam logic [3:0] S_RM_CMP = 4'd3;
	localparam logic [3:0] S_SH_CHK = 4'd4;
	localparam logic [3:0] S_SH_WR  = 4'd5;
	localparam logic [3:0] S_MOD_GO = 4'd6;
	localparam logic [3:0] S_MOD_W  = 4'd7;
	localparam logic [3:0] S_WIN_GO = 4'd8;
	localparam logic [3:0] S_WIN_W  = 4'd9;
	localparam logic [3:0] S_WK_RD  = 4'd10;
	localparam logic [3:0] S_WK_POP = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (st.func)
					twrqs_pkg::FN_ADD: begin
						cmd.set_status = 1'b1;
						state_d        = S_FIN;
						if (st.prio_bad) begin
							cmd.status = twrqs_pkg::ST_PRIO;
						end else if (st.full) begin
							cmd.status = twrqs_pkg::ST_FULL;
						end else begin
							cmd.status   = twrqs_pkg::ST_OK;
							cmd.add_push = 1'b1;
						end
					end
					twrqs_pkg::FN_REMOVE: begin
						if (st.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = twrqs_pkg::ST_NOTFOUND;
							state_d        = S_FIN;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_RM_RD;
						end
					end
					twrqs_pkg::FN_SCHED: begin
						if (st.empty || st.count_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = twrqs_pkg::ST_NOPICK;
							state_d        = S_FIN;
						end else begin
							state_d = S_MOD_GO;
						end
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status     = twrqs_pkg::ST_OK;
						state_d        = S_FIN;
					end
				endcase
			end
			// Linear search for the tag from the head.
			S_RM_RD: begin
				cmd.rm_rd = 1'b1;
				state_d   = S_RM_CMP;
			end
			S_RM_CMP: begin
				if (st.tag_hit) begin
					cmd.rm_hit = 1'b1;
					state_d    = S_SH_CHK;
				end else if (st.rm_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = twrqs_pkg::ST_NOTFOUND;
					state_d        = S_FIN;
				end else begin
					cmd.rm_next = 1'b1;
					state_d     = S_RM_RD;
				end
			end
			// Close the gap one entry at a time.
			S_SH_CHK: begin
				if (st.sh_more) begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SH_WR;
				end else begin
					cmd.rm_apply   = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = twrqs_pkg::ST_OK;
					state_d        = S_FIN;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SH_CHK;
			end
			// Draw the winning ticket with two divider runs.
			S_MOD_GO: begin
				cmd.div_mod_go = 1'b1;
				state_d        = S_MOD_W;
			end
			S_MOD_W: begin
				if (st.div_done) begin
					state_d = S_WIN_GO;
				end
			end
			S_WIN_GO: begin
				cmd.div_win_go = 1'b1;
				state_d        = S_WIN_W;
			end
			S_WIN_W: begin
				if (st.div_done) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WK_RD;
				end
			end
			// Pop, accumulate and rotate until the winner is reached.
			S_WK_RD: begin
				cmd.walk_rd = 1'b1;
				state_d     = S_WK_POP;
			end
			S_WK_POP: begin
				cmd.walk_pop = 1'b1;
				if (st.win) begin
					cmd.set_status = 1'b1;
					cmd.status     = twrqs_pkg::ST_OK;
					state_d        = S_FIN;
				end else if (st.pass_end && (st.no_gain || st.last_pass)) begin
					cmd.set_status = 1'b1;
					cmd.status     = twrqs_pkg::ST_NOPICK;
					state_d        = S_FIN;
				end else begin
					state_d = S_WK_RD;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/ticket_weighted_ready_queue_scheduler_unit.sv]
// Add goes straight to the result; remove searches entry by entry, then shifts each later entry.
// Schedule: setup and the two 33-step divider runs, then queue pops until the winner.
// One item at a time; the queue memory port and the divider set the pace.
// A new item is taken while the previous result waits in the output register.
// Reset (arst_n low) empties the queue and restores boot tickets, count and limit.
// The queue memory needs no clearing pass; only entries inside the ring are read.
module ticket_weighted_ready_queue_scheduler_unit #(
	parameter int QUEUE_DEPTH = twrqs_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_PASSES  = twrqs_pkg::MAX_PASSES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [twrqs_pkg::FUNC_W-1:0]  func,
	input  logic [twrqs_pkg::TAG_W-1:0]   task_tag,
	input  logic [twrqs_pkg::PRIO_W-1:0]  priority_req,
	input  logic [twrqs_pkg::TIME_W-1:0]  time_count,
	input  logic                          running_ends,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [twrqs_pkg::STAT_W-1:0]  status,
	output logic [twrqs_pkg::TAG_W-1:0]   picked_tag,
	output logic [twrqs_pkg::SUM_W-1:0]   ticket_total,
	input  logic                          cfg_we,
	input  logic [twrqs_pkg::LIM_W-1:0]   cfg_wdata
);

	twrqs_pkg::cmd_t  cmd;
	twrqs_pkg::stat_t st;

	twrqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	twrqs_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_PASSES (MAX_PASSES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.task_tag    (task_tag),
		.priority_req(priority_req),
		.time_count  (time_count),
		.running_ends(running_ends),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.st          (st),
		.status      (status),
		.picked_tag  (picked_tag),
		.ticket_total(ticket_total)
	);

endmodule

[rtl/twrqs_chk.sv]
// Port-level checker of the scheduler and its bind to the top level.
`include "ticket_weighted_ready_queue_scheduler_unit_defines.svh"

module twrqs_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [twrqs_pkg::STAT_W-1:0]  status,
	input logic [twrqs_pkg::TAG_W-1:0]   picked_tag,
	input logic [twrqs_pkg::SUM_W-1:0]   ticket_total
);

	// Only a successful schedule names a task.
	`TWRQS_CHECK(a_pick_only_ok, clk, arst_n, !(out_valid && (status != twrqs_pkg::ST_OK)) || (picked_tag == '0), "picked tag set on failed item")

	// One item at a time: an accepted item closes the input until it is done.
	`TWRQS_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready, "input open right after accept")

	// A stalled result holds.
	`TWRQS_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(picked_tag) && $stable(ticket_total), "result changed while stalled")

endmodule

bind ticket_weighted_ready_queue_scheduler_unit twrqs_chk u_chk (.*);
